// ===== rtl/alm_pkg.sv =====
package alm_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = 5;   // node index incl. "none"
  localparam int unsigned PosW     = 4;
  localparam logic [IdxW-1:0] NoneIdx = IdxW'(Capacity);

  typedef enum logic [2:0] {
    MODE_ADD_FRONT = 3'd0,
    MODE_ADD_END   = 3'd1,
    MODE_INSERT    = 3'd2,
    MODE_REMOVE    = 3'd3,
    MODE_SEARCH    = 3'd4,
    MODE_WRITE     = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOT_FND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [PosW-1:0]   position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] old_value;
    logic [IdxW-1:0]    result_index;
    logic [IdxW-1:0]    count;
  } rsp_t;

  // controller -> datapath commands
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,       // capture request
    CMD_TAKE,       // allocate free node (value, link none)
    CMD_LINK_HEAD,  // new node links to head, head = new
    CMD_SET_HEAD,   // head = new node
    CMD_WALK,       // cur = link[cur]
    CMD_TAIL_LINK,  // link[cur] = new
    CMD_INS_LINK,   // link[new] = link[pos], link[pos] = new
    CMD_REM_HEAD,   // head = link[pos], free pos
    CMD_REM_PRED,   // link[cur] = link[pos], free pos
    CMD_REM_FREE,   // free pos only
    CMD_WRITE,      // value[pos] = req value
    CMD_START_WALK  // cur = head
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic       rsp_load;
    logic [1:0] status;
    logic [1:0] res_sel;  // 0 none, 1 new node, 2 cur, 3 pos / link[pos]
    logic       old_sel;  // old value from value[pos]
  } ctl_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       pos_listed;
    logic       free_avail;
    logic       head_none;
    logic       pos_is_head;
    logic       cur_none;
    logic       cur_link_end;   // link[cur] is none or equals new node
    logic       cur_link_pos;   // link[cur] == pos
    logic       cur_val_match;
  } sts_t;

endpackage

// ===== rtl/alm_datapath.sv =====
module alm_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  alm_pkg::req_t req_i,
  input  alm_pkg::ctl_t ctl_i,
  output alm_pkg::sts_t sts_o,
  output alm_pkg::rsp_t rsp_o
);

  logic [alm_pkg::IdxW-1:0] link_q [alm_pkg::Capacity];
  logic [31:0]              val_q  [alm_pkg::Capacity];
  logic [alm_pkg::Capacity-1:0] listed_q;
  logic [alm_pkg::IdxW-1:0] head_q, free_q, cnt_q, cur_q, new_q;
  alm_pkg::req_t            req_q;
  alm_pkg::rsp_t            rsp_q;

  logic [alm_pkg::PosW-1:0] pos;
  logic [alm_pkg::PosW-1:0] cur_a, new_a, free_a;
  logic [alm_pkg::IdxW-1:0] pos_link;
  logic [alm_pkg::IdxW-1:0] res;

  assign pos    = req_q.position;
  assign cur_a  = cur_q[alm_pkg::PosW-1:0];
  assign new_a  = new_q[alm_pkg::PosW-1:0];
  assign free_a = free_q[alm_pkg::PosW-1:0];
  assign pos_link = link_q[pos];

  // status toward controller
  always_comb begin
    sts_o.mode          = req_q.mode;
    sts_o.pos_listed    = listed_q[pos];
    sts_o.free_avail    = (free_q != alm_pkg::NoneIdx);
    sts_o.head_none     = (head_q == alm_pkg::NoneIdx);
    sts_o.pos_is_head   = (head_q == {1'b0, pos});
    sts_o.cur_none      = (cur_q == alm_pkg::NoneIdx);
    sts_o.cur_link_end  = (link_q[cur_a] == alm_pkg::NoneIdx) || (link_q[cur_a] == new_q);
    sts_o.cur_link_pos  = (link_q[cur_a] == {1'b0, pos});
    sts_o.cur_val_match = (val_q[cur_a] == req_q.value);
  end

  always_comb begin
    unique case (ctl_i.res_sel)
      2'd0:    res = alm_pkg::NoneIdx;
      2'd1:    res = new_q;
      2'd2:    res = cur_q;
      default: res = (req_q.mode == alm_pkg::MODE_REMOVE) ? pos_link : {1'b0, pos};
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= alm_pkg::NoneIdx;
      free_q   <= '0;
      cnt_q    <= '0;
      listed_q <= '0;
      for (int i = 0; i < alm_pkg::Capacity; i++) begin
        link_q[i] <= (i == alm_pkg::Capacity - 1) ? alm_pkg::NoneIdx
                                                  : alm_pkg::IdxW'(i + 1);
      end
    end else begin
      unique case (ctl_i.cmd)
        alm_pkg::CMD_TAKE: begin
          free_q          <= link_q[free_a];
          link_q[free_a]  <= alm_pkg::NoneIdx;
          listed_q[free_a] <= 1'b1;
          cnt_q           <= cnt_q + 1'b1;
        end
        alm_pkg::CMD_LINK_HEAD: begin
          link_q[new_a] <= head_q;
          head_q        <= new_q;
        end
        alm_pkg::CMD_SET_HEAD:  head_q <= new_q;
        alm_pkg::CMD_TAIL_LINK: link_q[cur_a] <= new_q;
        alm_pkg::CMD_INS_LINK: begin
          link_q[new_a] <= pos_link;
          link_q[pos]   <= new_q;
        end
        alm_pkg::CMD_REM_HEAD, alm_pkg::CMD_REM_PRED, alm_pkg::CMD_REM_FREE: begin
          if (ctl_i.cmd == alm_pkg::CMD_REM_HEAD) head_q <= pos_link;
          if (ctl_i.cmd == alm_pkg::CMD_REM_PRED) link_q[cur_a] <= pos_link;
          link_q[pos]   <= free_q;
          free_q        <= {1'b0, pos};
          listed_q[pos] <= 1'b0;
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.cmd)
      alm_pkg::CMD_LOAD:       req_q <= req_i;
      alm_pkg::CMD_TAKE: begin
        new_q         <= free_q;
        val_q[free_a] <= req_q.value;
      end
      alm_pkg::CMD_START_WALK: cur_q <= head_q;
      alm_pkg::CMD_WALK:       cur_q <= link_q[cur_a];
      alm_pkg::CMD_WRITE:      val_q[pos] <= req_q.value;
      default: ;
    endcase
    if (ctl_i.rsp_load) begin
      rsp_q.status       <= ctl_i.status;
      rsp_q.old_value    <= ctl_i.old_sel ? val_q[pos] : '0;
      rsp_q.result_index <= res;
    end
    rsp_q.count <= cnt_q;
  end

  // count follows the element count every cycle; it is stable while the
  // response word waits, since no list update runs in that state
  assign rsp_o = rsp_q;

endmodule

// ===== rtl/alm_ctrl.sv =====
module alm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  alm_pkg::sts_t sts_i,
  output alm_pkg::ctl_t ctl_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DEC  = 8'b0000_0010,
    S_LINK = 8'b0000_0100,
    S_WALK = 8'b0000_1000,
    S_RMV  = 8'b0001_0000,
    S_SRCH = 8'b0010_0000,
    S_RESP = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] st_q, st_d;
  logic [1:0] rs_q, rs_d;
  logic       old_q, old_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    st_d = st_q; rs_d = rs_q; old_d = old_q;
    ctl_o = '{cmd: alm_pkg::CMD_NOP, rsp_load: 1'b0, status: st_q,
              res_sel: rs_q, old_sel: old_q};
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        ctl_o.cmd = alm_pkg::CMD_LOAD;
        state_d = S_DEC;
      end
      S_DEC: begin
        st_d = alm_pkg::ST_OK; rs_d = 2'd0; old_d = 1'b0;
        state_d = S_RESP;
        unique case (sts_i.mode)
          alm_pkg::MODE_ADD_FRONT, alm_pkg::MODE_ADD_END: begin
            if (!sts_i.free_avail) st_d = alm_pkg::ST_FULL;
            else begin
              ctl_o.cmd = alm_pkg::CMD_TAKE; rs_d = 2'd1; state_d = S_LINK;
            end
          end
          alm_pkg::MODE_INSERT: begin
            if (!sts_i.pos_listed) st_d = alm_pkg::ST_BAD_POS;
            else if (!sts_i.free_avail) st_d = alm_pkg::ST_FULL;
            else begin
              ctl_o.cmd = alm_pkg::CMD_TAKE; rs_d = 2'd1; state_d = S_LINK;
            end
          end
          alm_pkg::MODE_REMOVE: begin
            if (!sts_i.pos_listed) st_d = alm_pkg::ST_BAD_POS;
            else begin
              // capture old value and successor before unlinking
              ctl_o.rsp_load = 1'b1; ctl_o.status = alm_pkg::ST_OK;
              ctl_o.res_sel = 2'd3; ctl_o.old_sel = 1'b1;
              ctl_o.cmd = alm_pkg::CMD_START_WALK;
              rs_d = 2'd3; old_d = 1'b1;
              state_d = S_RMV;
            end
          end
          alm_pkg::MODE_SEARCH: begin
            st_d = alm_pkg::ST_NOT_FND;
            ctl_o.cmd = alm_pkg::CMD_START_WALK; state_d = S_SRCH;
          end
          alm_pkg::MODE_WRITE: begin
            if (!sts_i.pos_listed) st_d = alm_pkg::ST_BAD_POS;
            else begin
              ctl_o.rsp_load = 1'b1; ctl_o.status = alm_pkg::ST_OK;
              ctl_o.res_sel = 2'd3; ctl_o.old_sel = 1'b1;
              ctl_o.cmd = alm_pkg::CMD_WRITE;
              state_d = S_OUT;
            end
          end
          default: st_d = alm_pkg::ST_BAD_POS;
        endcase
      end
      S_LINK: begin
        state_d = S_RESP;
        unique case (sts_i.mode)
          alm_pkg::MODE_ADD_FRONT: ctl_o.cmd = alm_pkg::CMD_LINK_HEAD;
          alm_pkg::MODE_INSERT:    ctl_o.cmd = alm_pkg::CMD_INS_LINK;
          default: begin
            if (sts_i.head_none) ctl_o.cmd = alm_pkg::CMD_SET_HEAD;
            else begin
              ctl_o.cmd = alm_pkg::CMD_START_WALK; state_d = S_WALK;
            end
          end
        endcase
      end
      // tail walk: stop where link is none or the new node
      S_WALK: begin
        if (sts_i.cur_link_end) begin
          ctl_o.cmd = alm_pkg::CMD_TAIL_LINK; state_d = S_RESP;
        end else ctl_o.cmd = alm_pkg::CMD_WALK;
      end
      // predecessor walk for removal; response already captured
      S_RMV: begin
        if (sts_i.pos_is_head) begin
          ctl_o.cmd = alm_pkg::CMD_REM_HEAD; state_d = S_RESP;
        end else if (sts_i.cur_none) begin
          ctl_o.cmd = alm_pkg::CMD_REM_FREE; state_d = S_RESP;
        end else if (sts_i.cur_link_pos) begin
          ctl_o.cmd = alm_pkg::CMD_REM_PRED; state_d = S_RESP;
        end else ctl_o.cmd = alm_pkg::CMD_WALK;
      end
      S_SRCH: begin
        if (sts_i.cur_none) state_d = S_RESP;
        else if (sts_i.cur_val_match) begin
          st_d = alm_pkg::ST_OK; rs_d = 2'd2; state_d = S_RESP;
        end else ctl_o.cmd = alm_pkg::CMD_WALK;
      end
      S_RESP: begin
        ctl_o.rsp_load = 1'b1;
        if (sts_i.mode == alm_pkg::MODE_REMOVE && st_q == alm_pkg::ST_OK) begin
          // keep captured old value and successor, refresh count only
          ctl_o.rsp_load = 1'b0;
        end
        state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q <= '0; rs_q <= '0; old_q <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q <= st_d; rs_q <= rs_d; old_q <= old_d;
    end
  end

endmodule

// ===== rtl/array_linked_list_manager_unit.sv =====
// Linked list manager over a 16-node store with a free list.
// Input channel: in_valid_i / in_ready_o carry one request word
// (mode, position, value). Output channel: out_valid_o / out_ready_i
// carry one response word (status, old value, node index, count).
// One request is handled at a time; in_ready_o is high only when idle.
// Each request is taken in the idle state and decoded; a write at
// position then goes straight to the output state, errors pass the
// response state, add front / insert add a link step, search walks the
// nodes until a match or the end, add at end walks to the tail before
// linking, and remove walks to the predecessor before unlinking. The
// walks follow one link per cycle through the link store.
// The response register holds its word while out_ready_i is low and
// no new request is taken until the word leaves.
// Reset (async, active low) empties the list, chains all nodes into the
// free list and drops out_valid_o; no clearing pass is needed.
module array_linked_list_manager_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  alm_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output alm_pkg::rsp_t out_data_o
);

  alm_pkg::ctl_t ctl;
  alm_pkg::sts_t sts;
  alm_pkg::rsp_t rsp;

  alm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  alm_datapath u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .ctl_i(ctl), .sts_o(sts), .rsp_o(rsp)
  );

  // count is live so removals show the decremented value
  always_comb begin
    out_data_o = rsp;
  end

endmodule
